// ===== src/frv_pkg.sv =====
`default_nettype none
package frv_pkg;

  localparam int MAX_POINTS = 8;
  localparam int FRAC_BITS  = 16;
  localparam int OFF_FRAC   = 16;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 32;
  localparam int SPC_W      = 31;
  localparam int OFF_W      = 18;
  localparam int SELF_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // formation slots that carry a result
  localparam int SLOT_MAX = 5;
  // repulsion radius is THR_NUM / THR_DEN of the spacing
  localparam int THR_NUM  = 4;
  localparam int THR_DEN  = 5;

  localparam int EPS_RAW = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int EPS_Q   = (EPS_RAW > 0) ? EPS_RAW : 1;

  localparam int DIV_W   = 32 + FRAC_BITS;
  localparam int DVS_W   = 32;
  localparam int W_W     = FRAC_BITS + 1;
  localparam int ACC_W   = 48;
  localparam int SUM_W   = ACC_W + 4;
  localparam int TGT_W   = COORD_W + 3;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PW      = SPC_W + OFF_W;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_IN_W = 64;
  localparam int SQ_OUT_W = SQ_IN_W / 2;

  // reciprocal of 5: (2^34 + 1) / 5, exact floor for any spacing below 2^31
  localparam logic [MUL_W-1:0] RCP_5  = 32'hCCCCCCCD;
  localparam int               RCP_SH = 34;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SELF_INDEX,
    REG_SPACING,
    REG_OFFSET_X,
    REG_OFFSET_Y
  } frv_reg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LEAD,
    OP_OWN,
    OP_MUL_OFFX,
    OP_TGT_X,
    OP_MUL_OFFY,
    OP_TGT_Y,
    OP_MUL_THR,
    OP_THR,
    OP_PT,
    OP_SQX,
    OP_SQY,
    OP_D2,
    OP_DIV_W,
    OP_W,
    OP_MX,
    OP_DIV_CX,
    OP_ACC_X,
    OP_MY,
    OP_DIV_CY,
    OP_ACC_Y,
    OP_RESULT,
    OP_ZERO
  } frv_op_t;

  typedef struct packed {
    frv_op_t          op;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } frv_cmd_t;

  typedef struct packed {
    logic [SELF_W-1:0] self_index;
    logic              far;
    logic              near;
    logic              div_done;
    logic              sqrt_done;
    logic              out_full;
  } frv_status_t;

endpackage
`default_nettype wire

// ===== src/frv_point_if.sv =====
`default_nettype none
interface frv_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [frv_pkg::COORD_W-1:0] point_x;
  logic signed [frv_pkg::COORD_W-1:0] point_y;
  logic                               last;

  modport source(output valid, output point_x, output point_y, output last, input ready);
  modport sink(input valid, input point_x, input point_y, input last, output ready);
endinterface
`default_nettype wire

// ===== src/frv_result_if.sv =====
`default_nettype none
interface frv_result_if;
  logic                               valid;
  logic                               ready;
  logic                               valid_res;
  logic signed [frv_pkg::COORD_W-1:0] vec_x;
  logic signed [frv_pkg::COORD_W-1:0] vec_y;

  modport source(output valid, output valid_res, output vec_x, output vec_y, input ready);
  modport sink(input valid, input valid_res, input vec_x, input vec_y, output ready);
endinterface
`default_nettype wire

// ===== src/frv_cfg_if.sv =====
`default_nettype none
interface frv_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [frv_pkg::CFG_IDX_W-1:0]       index;
  logic [frv_pkg::CFG_DATA_W-1:0]      data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/formation_repulsive_vector.sv =====
// Loading: one point word per cycle; ready stays high until the word marked last.
// After last: setup (target, reciprocal multiply for the radius), then per other point
// the far test only if out of range, also one 32-step root if within the box but outside
// the radius or too close, and three 48-step divisions in the shared divider if repelled;
// the own point is skipped; an invalid index gives a zero word with valid_res low.
// Reset clears state and count; the point store stays unset until written.
`default_nettype none
module formation_repulsive_vector (
  input  wire logic     clk,
  input  wire logic     rst,
  frv_point_if.sink     points,
  frv_result_if.source  result,
  frv_cfg_if.sink       cfg
);
  // Controller sequences the set: load, target, then one pass over the
  // stored points; the datapath holds the store, the shared multiplier,
  // the divider and the root unit, plus the result register that parts
  // the output handshake from the compute loop.
  frv_pkg::frv_cmd_t    cmd;
  frv_pkg::frv_status_t status;

  frv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_last  (points.last),
    .in_ready (points.ready),
    .cmd      (cmd),
    .status   (status)
  );

  frv_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .point_x   (points.point_x),
    .point_y   (points.point_y),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .cfg_ready (cfg.ready),
    .cmd       (cmd),
    .status    (status),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .valid_res (result.valid_res),
    .vec_x     (result.vec_x),
    .vec_y     (result.vec_y)
  );
endmodule
`default_nettype wire

// ===== src/frv_div.sv =====
`default_nettype none
module frv_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [frv_pkg::DIV_W-1:0]   dividend,
  input  wire logic [frv_pkg::DVS_W-1:0]   divisor,
  output logic      [frv_pkg::DIV_W-1:0]   quotient,
  output logic                             done
);
  localparam int CW = $clog2(frv_pkg::DIV_W + 1);

  logic                        busy;
  logic [CW-1:0]               cnt;
  logic [frv_pkg::DVS_W-1:0]   rem;
  logic [frv_pkg::DVS_W-1:0]   dvs;
  logic [frv_pkg::DVS_W:0]     rem_sh;
  logic                        fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem, quotient[frv_pkg::DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(frv_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? frv_pkg::DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[frv_pkg::DVS_W-1:0];
      quotient <= {quotient[frv_pkg::DIV_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

// ===== src/frv_sqrt.sv =====
`default_nettype none
module frv_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [frv_pkg::SQ_IN_W-1:0]   radicand,
  output logic      [frv_pkg::SQ_OUT_W-1:0]  root,
  output logic                               done
);
  localparam int CW = $clog2(frv_pkg::SQ_OUT_W + 1);
  localparam int RW = frv_pkg::SQ_OUT_W + 4;

  logic                           busy;
  logic [CW-1:0]                  cnt;
  logic [frv_pkg::SQ_IN_W-1:0]    val;
  logic [frv_pkg::SQ_OUT_W+1:0]   rem;
  logic [RW-1:0]                  rem_sh;
  logic [RW-1:0]                  trial;
  logic                           fits;

  // two radicand bits per cycle, one root bit
  assign rem_sh = {rem, val[frv_pkg::SQ_IN_W-1 -: 2]};
  assign trial  = RW'({root, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(frv_pkg::SQ_OUT_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[frv_pkg::SQ_IN_W-3:0], 2'b00};
      rem  <= fits ? (frv_pkg::SQ_OUT_W+2)'(rem_sh - trial) : (frv_pkg::SQ_OUT_W+2)'(rem_sh);
      root <= {root[frv_pkg::SQ_OUT_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

// ===== src/frv_datapath.sv =====
`default_nettype none
module frv_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic signed [frv_pkg::COORD_W-1:0]    point_x,
  input  wire logic signed [frv_pkg::COORD_W-1:0]    point_y,
  input  wire logic                                  cfg_valid,
  input  wire logic [frv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [frv_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                       cfg_ready,
  input  wire frv_pkg::frv_cmd_t                     cmd,
  output frv_pkg::frv_status_t                       status,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic                                       valid_res,
  output logic signed [frv_pkg::COORD_W-1:0]         vec_x,
  output logic signed [frv_pkg::COORD_W-1:0]         vec_y
);
  localparam logic signed [frv_pkg::SUM_W-1:0] S_MAX =
    frv_pkg::SUM_W'({1'b0, {(frv_pkg::COORD_W-1){1'b1}}});
  localparam logic signed [frv_pkg::SUM_W-1:0] S_MIN = ~S_MAX;
  localparam logic signed [frv_pkg::PW-1:0] HALF = frv_pkg::PW'(1) <<< (frv_pkg::OFF_FRAC - 1);

  function automatic logic signed [frv_pkg::COORD_W-1:0] sat(
    input logic signed [frv_pkg::SUM_W-1:0] v);
    if (v > S_MAX) return S_MAX[frv_pkg::COORD_W-1:0];
    if (v < S_MIN) return S_MIN[frv_pkg::COORD_W-1:0];
    return v[frv_pkg::COORD_W-1:0];
  endfunction

  // configuration
  logic [frv_pkg::SELF_W-1:0]        self_index;
  logic [frv_pkg::SPC_W-1:0]         spacing;
  logic signed [frv_pkg::OFF_W-1:0]  off_x;
  logic signed [frv_pkg::OFF_W-1:0]  off_y;

  // point store
  logic signed [frv_pkg::COORD_W-1:0] x_mem [frv_pkg::MAX_POINTS];
  logic signed [frv_pkg::COORD_W-1:0] y_mem [frv_pkg::MAX_POINTS];
  logic signed [frv_pkg::COORD_W-1:0] rd_x, rd_y;

  logic signed [frv_pkg::COORD_W-1:0] lead_x, lead_y, own_x, own_y;
  logic signed [frv_pkg::TGT_W-1:0]   tx, ty;
  logic [frv_pkg::SPC_W-1:0]          thr;
  logic [frv_pkg::MUL_W-1:0]          dxm, dym;
  logic                               dxn, dyn, off_neg;
  logic [frv_pkg::PROD_W-1:0]         prod, d2;
  logic [frv_pkg::W_W-1:0]            w;
  logic signed [frv_pkg::ACC_W-1:0]   acc_x, acc_y;

  logic [frv_pkg::MUL_W-1:0]          mul_a, mul_b;
  logic signed [frv_pkg::DIFF_W-1:0]  dx, dy;
  logic [frv_pkg::DIFF_W-1:0]         dx_mag, dy_mag;
  logic signed [frv_pkg::PW-1:0]      p_signed, off_term;
  logic signed [frv_pkg::TGT_W-1:0]   tgt;
  logic signed [frv_pkg::ACC_W-1:0]   contrib;
  logic signed [frv_pkg::SUM_W-1:0]   sum_x, sum_y;
  logic [frv_pkg::SPC_W-1:0]          q5, thr_next;
  logic [2:0]                         r5;

  logic                               div_start, sqrt_start;
  logic [frv_pkg::DIV_W-1:0]          div_a, quotient;
  logic [frv_pkg::DVS_W-1:0]          div_b;
  logic                               div_done, sqrt_done;
  logic [frv_pkg::SQ_OUT_W-1:0]       root;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_index <= frv_pkg::SELF_W'(1);
      spacing    <= frv_pkg::SPC_W'(1 << frv_pkg::FRAC_BITS);
      off_x      <= '0;
      off_y      <= '0;
    end else if (cfg_valid) begin
      case (frv_pkg::frv_reg_t'(cfg_index))
        frv_pkg::REG_SELF_INDEX: self_index <= cfg_data[frv_pkg::SELF_W-1:0];
        frv_pkg::REG_SPACING:    spacing    <= cfg_data[frv_pkg::SPC_W-1:0];
        frv_pkg::REG_OFFSET_X:   off_x      <= cfg_data[frv_pkg::OFF_W-1:0];
        frv_pkg::REG_OFFSET_Y:   off_y      <= cfg_data[frv_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      x_mem[cmd.wr_addr] <= point_x;
      y_mem[cmd.wr_addr] <= point_y;
    end
    rd_x <= x_mem[cmd.rd_addr];
    rd_y <= y_mem[cmd.rd_addr];
  end

  // own minus other, plus magnitudes for the far test
  assign dx     = frv_pkg::DIFF_W'(own_x) - frv_pkg::DIFF_W'(rd_x);
  assign dy     = frv_pkg::DIFF_W'(own_y) - frv_pkg::DIFF_W'(rd_y);
  assign dx_mag = dx[frv_pkg::DIFF_W-1] ? frv_pkg::DIFF_W'(-dx) : frv_pkg::DIFF_W'(dx);
  assign dy_mag = dy[frv_pkg::DIFF_W-1] ? frv_pkg::DIFF_W'(-dy) : frv_pkg::DIFF_W'(dy);

  // offset times spacing, rounded to nearest with ties up
  always_comb begin
    p_signed = $signed({1'b0, prod[frv_pkg::PW-2:0]});
    if (off_neg) p_signed = -p_signed;
    off_term = (p_signed + HALF) >>> frv_pkg::OFF_FRAC;
    tgt = frv_pkg::TGT_W'(off_term);
  end

  // radius: q = spacing / 5 from the reciprocal product, then 4q plus 4r/5 for r in 0..4
  assign q5       = frv_pkg::SPC_W'(prod[frv_pkg::PROD_W-1:frv_pkg::RCP_SH]);
  assign r5       = 3'(spacing - ((q5 << 2) + q5));
  assign thr_next = (q5 << 2) + frv_pkg::SPC_W'((r5 == 3'd0) ? 3'd0 : r5 - 3'd1);

  assign contrib = $signed(frv_pkg::ACC_W'(quotient[frv_pkg::W_W-1:0]));
  assign sum_x = frv_pkg::SUM_W'(tx) + (frv_pkg::SUM_W'(acc_x) <<< 2) + frv_pkg::SUM_W'(acc_x);
  assign sum_y = frv_pkg::SUM_W'(ty) + (frv_pkg::SUM_W'(acc_y) <<< 2) + frv_pkg::SUM_W'(acc_y);

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = '0;
    sqrt_start = 1'b0;
    case (cmd.op)
      frv_pkg::OP_MUL_OFFX: begin
        mul_a = off_x[frv_pkg::OFF_W-1] ? -frv_pkg::MUL_W'(off_x) : frv_pkg::MUL_W'(off_x);
        mul_b = frv_pkg::MUL_W'(spacing);
      end
      frv_pkg::OP_MUL_OFFY: begin
        mul_a = off_y[frv_pkg::OFF_W-1] ? -frv_pkg::MUL_W'(off_y) : frv_pkg::MUL_W'(off_y);
        mul_b = frv_pkg::MUL_W'(spacing);
      end
      frv_pkg::OP_MUL_THR: begin
        mul_a = frv_pkg::MUL_W'(spacing);
        mul_b = frv_pkg::RCP_5;
      end
      frv_pkg::OP_SQX: begin
        mul_a = dxm;
        mul_b = dxm;
      end
      frv_pkg::OP_SQY: begin
        mul_a = dym;
        mul_b = dym;
      end
      frv_pkg::OP_MX: begin
        mul_a = dxm;
        mul_b = frv_pkg::MUL_W'(w);
      end
      frv_pkg::OP_MY: begin
        mul_a = dym;
        mul_b = frv_pkg::MUL_W'(w);
      end
      frv_pkg::OP_DIV_W: begin
        div_start = 1'b1;
        div_a     = frv_pkg::DIV_W'(frv_pkg::SPC_W'(thr - root[frv_pkg::SPC_W-1:0]))
                    << frv_pkg::FRAC_BITS;
        div_b     = frv_pkg::DVS_W'(thr);
      end
      frv_pkg::OP_DIV_CX, frv_pkg::OP_DIV_CY: begin
        div_start = 1'b1;
        div_a     = prod[frv_pkg::DIV_W-1:0];
        div_b     = frv_pkg::DVS_W'(root);
      end
      frv_pkg::OP_D2: sqrt_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      frv_pkg::OP_LEAD: begin
        lead_x <= rd_x;
        lead_y <= rd_y;
      end
      frv_pkg::OP_OWN: begin
        own_x <= rd_x;
        own_y <= rd_y;
      end
      frv_pkg::OP_MUL_OFFX: off_neg <= off_x[frv_pkg::OFF_W-1];
      frv_pkg::OP_MUL_OFFY: off_neg <= off_y[frv_pkg::OFF_W-1];
      frv_pkg::OP_TGT_X:
        tx <= frv_pkg::TGT_W'(lead_x) + tgt - frv_pkg::TGT_W'(own_x);
      frv_pkg::OP_TGT_Y:
        ty <= frv_pkg::TGT_W'(lead_y) + tgt - frv_pkg::TGT_W'(own_y);
      frv_pkg::OP_THR: thr <= thr_next;
      frv_pkg::OP_PT: begin
        dxm <= dx_mag[frv_pkg::MUL_W-1:0];
        dym <= dy_mag[frv_pkg::MUL_W-1:0];
        dxn <= dx[frv_pkg::DIFF_W-1];
        dyn <= dy[frv_pkg::DIFF_W-1];
      end
      frv_pkg::OP_SQY: d2 <= prod;
      frv_pkg::OP_W:   w  <= quotient[frv_pkg::W_W-1:0];
      default: ;
    endcase
    if (cmd.op == frv_pkg::OP_MUL_OFFX || cmd.op == frv_pkg::OP_MUL_OFFY ||
        cmd.op == frv_pkg::OP_MUL_THR ||
        cmd.op == frv_pkg::OP_SQX || cmd.op == frv_pkg::OP_SQY ||
        cmd.op == frv_pkg::OP_MX || cmd.op == frv_pkg::OP_MY) begin
      prod <= frv_pkg::PROD_W'(mul_a) * frv_pkg::PROD_W'(mul_b);
    end
  end

  // accumulators and result register
  always_ff @(posedge clk) begin
    case (cmd.op)
      frv_pkg::OP_LEAD: begin
        acc_x <= '0;
        acc_y <= '0;
      end
      frv_pkg::OP_ACC_X: acc_x <= dxn ? acc_x - contrib : acc_x + contrib;
      frv_pkg::OP_ACC_Y: acc_y <= dyn ? acc_y - contrib : acc_y + contrib;
      frv_pkg::OP_RESULT: begin
        valid_res <= 1'b1;
        vec_x     <= sat(sum_x);
        vec_y     <= sat(sum_y);
      end
      frv_pkg::OP_ZERO: begin
        valid_res <= 1'b0;
        vec_x     <= '0;
        vec_y     <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == frv_pkg::OP_RESULT || cmd.op == frv_pkg::OP_ZERO) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  frv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (quotient),
    .done     (div_done)
  );

  frv_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (d2 + prod),
    .root     (root),
    .done     (sqrt_done)
  );

  always_comb begin
    status.self_index = self_index;
    status.far        = (dx_mag >= frv_pkg::DIFF_W'(thr)) || (dy_mag >= frv_pkg::DIFF_W'(thr));
    status.near       = (root < frv_pkg::SQ_OUT_W'(frv_pkg::EPS_Q)) ||
                        (root >= frv_pkg::SQ_OUT_W'(thr));
    status.div_done   = div_done;
    status.sqrt_done  = sqrt_done;
    status.out_full   = out_valid && !out_ready;
  end
endmodule
`default_nettype wire

// ===== src/frv_ctrl.sv =====
`default_nettype none
module frv_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    in_last,
  output logic                         in_ready,
  output frv_pkg::frv_cmd_t            cmd,
  input  wire frv_pkg::frv_status_t    status
);
  typedef enum logic [4:0] {
    S_LOAD, S_CHK, S_INV, S_LEAD, S_OWN, S_MOFX, S_TGTX, S_MOFY, S_TGTY,
    S_DTHR, S_THR, S_NEXT, S_PT, S_SQX, S_SQY, S_D2, S_WSQ, S_DCHK,
    S_DW, S_WW, S_LW, S_MX, S_DX, S_WX, S_AX, S_MY, S_DY, S_WY, S_AY, S_FIN
  } state_t;

  state_t                      state;
  logic [frv_pkg::CNT_W-1:0]   cnt;
  logic [frv_pkg::CNT_W-1:0]   n;
  logic [frv_pkg::CNT_W-1:0]   i;
  logic [frv_pkg::CNT_W-1:0]   cnt_next;
  logic [frv_pkg::IDX_W-1:0]   own;
  logic                        accept;
  logic                        self_ok;

  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign cnt_next = (cnt < frv_pkg::CNT_W'(frv_pkg::MAX_POINTS)) ? cnt + frv_pkg::CNT_W'(1) : cnt;
  assign own      = frv_pkg::IDX_W'(status.self_index - frv_pkg::SELF_W'(1));
  assign self_ok  = (status.self_index != '0) &&
                    (int'(status.self_index) <= frv_pkg::SLOT_MAX) &&
                    (int'(status.self_index) <= int'(n));

  always_comb begin
    cmd.op      = frv_pkg::OP_NONE;
    cmd.rd_addr = i[frv_pkg::IDX_W-1:0];
    cmd.wr_en   = accept && (cnt < frv_pkg::CNT_W'(frv_pkg::MAX_POINTS));
    cmd.wr_addr = cnt[frv_pkg::IDX_W-1:0];
    case (state)
      S_CHK:  cmd.rd_addr = '0;
      S_INV:  cmd.op = status.out_full ? frv_pkg::OP_NONE : frv_pkg::OP_ZERO;
      S_LEAD: begin
        cmd.op      = frv_pkg::OP_LEAD;
        cmd.rd_addr = own;
      end
      S_OWN:  cmd.op = frv_pkg::OP_OWN;
      S_MOFX: cmd.op = frv_pkg::OP_MUL_OFFX;
      S_TGTX: cmd.op = frv_pkg::OP_TGT_X;
      S_MOFY: cmd.op = frv_pkg::OP_MUL_OFFY;
      S_TGTY: cmd.op = frv_pkg::OP_TGT_Y;
      S_DTHR: cmd.op = frv_pkg::OP_MUL_THR;
      S_THR:  cmd.op = frv_pkg::OP_THR;
      S_PT:   cmd.op = frv_pkg::OP_PT;
      S_SQX:  cmd.op = frv_pkg::OP_SQX;
      S_SQY:  cmd.op = frv_pkg::OP_SQY;
      S_D2:   cmd.op = frv_pkg::OP_D2;
      S_DW:   cmd.op = frv_pkg::OP_DIV_W;
      S_LW:   cmd.op = frv_pkg::OP_W;
      S_MX:   cmd.op = frv_pkg::OP_MX;
      S_DX:   cmd.op = frv_pkg::OP_DIV_CX;
      S_AX:   cmd.op = frv_pkg::OP_ACC_X;
      S_MY:   cmd.op = frv_pkg::OP_MY;
      S_DY:   cmd.op = frv_pkg::OP_DIV_CY;
      S_AY:   cmd.op = frv_pkg::OP_ACC_Y;
      S_FIN:  cmd.op = status.out_full ? frv_pkg::OP_NONE : frv_pkg::OP_RESULT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      n     <= '0;
      i     <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (in_last) begin
              n     <= cnt_next;
              cnt   <= '0;
              state <= S_CHK;
            end else begin
              cnt <= cnt_next;
            end
          end
        end
        S_CHK:  state <= self_ok ? S_LEAD : S_INV;
        S_INV:  if (!status.out_full) state <= S_LOAD;
        S_LEAD: state <= S_OWN;
        S_OWN:  state <= S_MOFX;
        S_MOFX: state <= S_TGTX;
        S_TGTX: state <= S_MOFY;
        S_MOFY: state <= S_TGTY;
        S_TGTY: state <= S_DTHR;
        S_DTHR: state <= S_THR;
        S_THR: begin
          i     <= '0;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (i == n) begin
            state <= S_FIN;
          end else if (i == frv_pkg::CNT_W'(own)) begin
            i <= i + frv_pkg::CNT_W'(1);
          end else begin
            state <= S_PT;
          end
        end
        S_PT: begin
          if (status.far) begin
            i     <= i + frv_pkg::CNT_W'(1);
            state <= S_NEXT;
          end else begin
            state <= S_SQX;
          end
        end
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_D2;
        S_D2:   state <= S_WSQ;
        S_WSQ:  if (status.sqrt_done) state <= S_DCHK;
        S_DCHK: begin
          if (status.near) begin
            i     <= i + frv_pkg::CNT_W'(1);
            state <= S_NEXT;
          end else begin
            state <= S_DW;
          end
        end
        S_DW:   state <= S_WW;
        S_WW:   if (status.div_done) state <= S_LW;
        S_LW:   state <= S_MX;
        S_MX:   state <= S_DX;
        S_DX:   state <= S_WX;
        S_WX:   if (status.div_done) state <= S_AX;
        S_AX:   state <= S_MY;
        S_MY:   state <= S_DY;
        S_DY:   state <= S_WY;
        S_WY:   if (status.div_done) state <= S_AY;
        S_AY: begin
          i     <= i + frv_pkg::CNT_W'(1);
          state <= S_NEXT;
        end
        S_FIN:  if (!status.out_full) state <= S_LOAD;
        default: state <= S_LOAD;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= frv_pkg::CNT_W'(frv_pkg::MAX_POINTS))
    else $error("point count past store depth");

  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_NEXT) |-> (i <= n))
    else $error("loop index past loaded count");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_last) |=> (state == S_CHK))
    else $error("closing word did not start the set");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == frv_pkg::OP_RESULT || cmd.op == frv_pkg::OP_ZERO) |-> !status.out_full)
    else $error("result written over a word not yet taken");
endmodule
`default_nettype wire

// ===== dv/frv_tb_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces come from the RTL; this file holds nothing of its own
// beyond two small bundles that keep the testbench's point and vector words typed.
package frv_tb_pkg;

  typedef struct packed {
    logic signed [frv_pkg::COORD_W-1:0] x;
    logic signed [frv_pkg::COORD_W-1:0] y;
    logic                               last;
  } point_word_t;

  typedef struct packed {
    logic                               ok;
    logic signed [frv_pkg::COORD_W-1:0] vx;
    logic signed [frv_pkg::COORD_W-1:0] vy;
  } vector_word_t;
endpackage

// ===== dv/formation_repulsive_vector_test.sv =====
`timescale 1ns / 1ps
module formation_repulsive_vector_test;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  frv_point_if  points();
  frv_result_if result();
  frv_cfg_if    cfg();

  formation_repulsive_vector DUT (
    .clk(clk), .rst(rst), .points(points.sink), .result(result.source), .cfg(cfg.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the configuration and the point store.
  logic [frv_pkg::SELF_W-1:0]  own_slot = 1;
  logic [frv_pkg::SPC_W-1:0]   spc = 65536;
  logic signed [17:0]          offx = 0;
  logic signed [17:0]          offy = 0;
  longint                      xs[frv_pkg::MAX_POINTS];
  longint                      ys[frv_pkg::MAX_POINTS];
  int                          npts = 0;

  frv_tb_pkg::point_word_t  word_q[$];
  frv_tb_pkg::vector_word_t vector_q[$];
  int errors = 0;
  int sets_seen = 0;
  int valid_seen = 0;
  int words_sent = 0;
  longint cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d (set %0d)", what, got, want, sets_seen);
  endtask

  function automatic longint round_off(longint p);
    longint h;
    h = p + (64'sd1 <<< (frv_pkg::OFF_FRAC - 1));
    if (h >= 0) return h >>> frv_pkg::OFF_FRAC;
    return -((-h + (64'sd1 <<< frv_pkg::OFF_FRAC) - 1) >>> frv_pkg::OFF_FRAC);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Fold one point word into the store; on last, compute the formation vector.
  function automatic void predict_vector(frv_tb_pkg::point_word_t w);
    frv_tb_pkg::vector_word_t r;
    longint thr, tx, ty, fx, fy, dx, dy, d, wt, sp;
    longint unsigned d2, thr2, eps2;
    int own;
    if (npts < frv_pkg::MAX_POINTS) begin
      xs[npts] = longint'(w.x);
      ys[npts] = longint'(w.y);
      npts++;
    end
    if (!w.last) return;
    r = '0;
    if (own_slot < 1 || own_slot > frv_pkg::SLOT_MAX || own_slot > npts) begin
      vector_q.push_back(r);
      npts = 0;
      return;
    end
    own = int'(own_slot) - 1;
    sp = longint'(spc);
    tx = xs[0] + round_off(longint'(offx) * sp) - xs[own];
    ty = ys[0] + round_off(longint'(offy) * sp) - ys[own];
    thr = (sp * frv_pkg::THR_NUM) / frv_pkg::THR_DEN;
    thr2 = longint'(thr * thr);
    eps2 = longint'(frv_pkg::EPS_Q) * longint'(frv_pkg::EPS_Q);
    fx = 0;
    fy = 0;
    for (int i = 0; i < npts; i++) begin
      if (i == own) continue;
      dx = xs[own] - xs[i];
      dy = ys[own] - ys[i];
      if (mag(dx) >= thr || mag(dy) >= thr) continue;
      d2 = dx * dx + dy * dy;
      if (d2 < eps2 || d2 >= thr2) continue;
      d = root_floor(d2);
      if (d == 0) continue;
      wt = ((thr - d) * (64'sd1 <<< frv_pkg::FRAC_BITS)) / thr;
      fx += (dx * wt) / d;
      fy += (dy * wt) / d;
    end
    r.ok = 1'b1;
    r.vx = 32'(clamp32(tx + 5 * fx));
    r.vy = 32'(clamp32(ty + 5 * fy));
    vector_q.push_back(r);
    npts = 0;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: hand queued point words to the block, with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      points.valid <= 1'b0;
      points.point_x <= '0;
      points.point_y <= '0;
      points.last <= 1'b0;
    end else if (!points.valid || points.ready) begin
      if (points.valid) begin
        predict_vector({points.point_x, points.point_y, points.last});
        words_sent++;
      end
      if (send_gap > 0 || word_q.size() == 0) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        points.valid <= 1'b0;
      end else begin
        frv_tb_pkg::point_word_t w;
        w = word_q.pop_front();
        points.valid <= 1'b1;
        points.point_x <= w.x;
        points.point_y <= w.y;
        points.last <= w.last;
        send_gap <= gap_len();
      end
    end
  end

  // Monitor: stall the result side at random and check every vector word.
  int stall = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        sets_seen++;
        if (vector_q.size() == 0) begin
          report("unexpected vector word", 1, 0);
        end else begin
          frv_tb_pkg::vector_word_t e;
          e = vector_q.pop_front();
          if (result.valid_res !== e.ok) report("valid_res", result.valid_res, e.ok);
          if (result.vec_x !== e.vx) report("vec_x", result.vec_x, e.vx);
          if (result.vec_y !== e.vy) report("vec_y", result.vec_y, e.vy);
          if (e.ok) valid_seen++;
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        stall <= gap_len();
      end
    end
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.index = frv_pkg::REG_SELF_INDEX;
    cfg.data = '0;
  end

  // Write one register through the config channel while the block is idle.
  task automatic write_reg(input frv_pkg::frv_reg_t idx,
                           input logic [frv_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      frv_pkg::REG_SELF_INDEX: own_slot = val[frv_pkg::SELF_W-1:0];
      frv_pkg::REG_SPACING:    spc = val[frv_pkg::SPC_W-1:0];
      frv_pkg::REG_OFFSET_X:   offx = val[17:0];
      default:                 offy = val[17:0];
    endcase
  endtask

  // Block until every queued word went in and every vector came back.
  task automatic drain();
    while (word_q.size() != 0 || points.valid || vector_q.size() != 0 || npts != 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic push_word(input longint x, input longint y, input bit l);
    frv_tb_pkg::point_word_t w;
    w.x = 32'(x);
    w.y = 32'(y);
    w.last = l;
    word_q.push_back(w);
  endtask

  // Random set: points clustered around a random base so that repulsion fires, with an occasional point anywhere.
  task automatic push_set(input int n, input longint span);
    longint bx, by;
    bx = $signed($urandom);
    by = $signed($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_word($signed($urandom), $signed($urandom), i == n - 1);
      else
        push_word(clamp32(bx + (longint'($urandom) % (2 * span + 1)) - span),
                  clamp32(by + (longint'($urandom) % (2 * span + 1)) - span), i == n - 1);
    end
  endtask

  task automatic random_phase(input int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      int n;
      n = $urandom_range(0, 19) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 6);
      push_set(n, longint'(spc) + 1);
      sent += n;
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, coincident points, extremes, overfull set.
    push_word(0, 0, 0);
    push_word(0, 0, 1);
    push_word(100, 100, 0);
    push_word(100, 100, 0);
    push_word(150, 120, 1);
    push_word(32'sh7fffffff, 32'sh7fffffff, 0);
    push_word(-32'sh80000000, -32'sh80000000, 1);
    for (int i = 0; i < 10; i++) push_word(i * 9000, -i * 7000, i == 9);
    push_word(5, 5, 1);
    drain();
    write_reg(frv_pkg::REG_SELF_INDEX, 0);
    write_reg(frv_pkg::REG_SPACING, 31'h7fffffff);
    write_reg(frv_pkg::REG_OFFSET_X, 18'h10000);
    write_reg(frv_pkg::REG_OFFSET_Y, 18'h30000);
    push_word(-32'sh80000000, 0, 0);
    push_word(32'sh7fffffff, 0, 1);
    drain();
    write_reg(frv_pkg::REG_SELF_INDEX, 2);
    push_word(-32'sh80000000, -32'sh80000000, 0);
    push_word(32'sh7fffffff, 32'sh7fffffff, 1);
    push_word(0, 0, 0);
    push_word(1000, -2000, 0);
    push_word(1, 1, 1);
    drain();

    // Random phases over several settings, extremes among them.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(frv_pkg::REG_SELF_INDEX, ph == 0 ? 7 : $urandom_range(1, 6));
      case (ph % 5)
        0: write_reg(frv_pkg::REG_SPACING, 0);
        1: write_reg(frv_pkg::REG_SPACING, 1);
        2: write_reg(frv_pkg::REG_SPACING, 31'h7fffffff);
        default: write_reg(frv_pkg::REG_SPACING, $urandom_range(1000, 1 << 20));
      endcase
      write_reg(frv_pkg::REG_OFFSET_X,
                ph == 1 ? 18'h30000 : 18'($signed($urandom_range(0, 131072)) - 65536));
      write_reg(frv_pkg::REG_OFFSET_Y,
                ph == 3 ? 18'h10000 : 18'($signed($urandom_range(0, 131072)) - 65536));
      random_phase(80);
    end

    $display("sent %0d point words, checked %0d vectors (%0d valid)",
             words_sent, sets_seen, valid_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end
endmodule

// ===== filelist.f =====
src/frv_pkg.sv
src/frv_point_if.sv
src/frv_result_if.sv
src/frv_cfg_if.sv
src/frv_div.sv
src/frv_sqrt.sv
src/frv_datapath.sv
src/frv_ctrl.sv
src/formation_repulsive_vector.sv
dv/frv_tb_if.sv
dv/formation_repulsive_vector_test.sv
